### rtl/sgbn_pkg.sv
// Shared types and constants for the SACK gap block normalizer.
package sgbn_pkg;

  // Number of sorting cells, one gap block per cell
  localparam int unsigned MaxBlocks = 32;
  localparam int unsigned OffsW     = 16;

  // One stored gap block
  typedef struct packed {
    logic             valid;
    logic [OffsW-1:0] start;
    logic [OffsW-1:0] stop;
  } blk_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic             insert;
    logic             shift;
    logic [OffsW-1:0] blk_start;
    logic [OffsW-1:0] blk_stop;
  } chain_ctrl_t;

  // Status from the merge unit back to the controller
  typedef struct packed {
    logic shift;
    logic done;
  } merge_stat_t;

endpackage

### rtl/sgbn_cell.sv
// One sorting cell: holds a block, takes a new or shifted-in block, shifts out when draining.
module sgbn_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sgbn_pkg::chain_ctrl_t ctrl_i,
  input  logic                 prev_take_i,
  input  sgbn_pkg::blk_t       prev_blk_i,
  input  sgbn_pkg::blk_t       next_blk_i,
  output logic                 take_o,
  output sgbn_pkg::blk_t       blk_o
);

  logic                       valid_q;
  logic [sgbn_pkg::OffsW-1:0] start_q, stop_q;
  sgbn_pkg::blk_t             blk_cur, blk_d;

  assign blk_cur = {valid_q, start_q, stop_q};

  // cell takes the insert when it is empty or the new block sorts before its content
  assign take_o = ctrl_i.insert && (!blk_cur.valid || (ctrl_i.blk_start < blk_cur.start));

  always_comb begin
    blk_d = blk_cur;
    if (ctrl_i.shift) begin
      blk_d = next_blk_i;
    end else if (take_o) begin
      if (prev_take_i) begin
        blk_d = prev_blk_i;
      end else begin
        blk_d.valid = 1'b1;
        blk_d.start = ctrl_i.blk_start;
        blk_d.stop  = ctrl_i.blk_stop;
      end
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= blk_d.valid;
    end
  end

  // offsets
  always_ff @(posedge clk_i) begin
    start_q <= blk_d.start;
    stop_q  <= blk_d.stop;
  end

  assign blk_o = blk_cur;

endmodule

### rtl/sgbn_merge.sv
// Merge unit: folds sorted blocks from the chain head and drives the output register.
module sgbn_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         emit_i,
  input  sgbn_pkg::blk_t               head_i,
  input  logic                         ovf_i,
  input  logic                         ready_i,
  output sgbn_pkg::merge_stat_t        stat_o,
  output logic                         valid_o,
  output logic [sgbn_pkg::OffsW-1:0]   start_o,
  output logic [sgbn_pkg::OffsW-1:0]   stop_o,
  output logic                         none_o,
  output logic                         ovf_o,
  output logic                         last_o
);

  logic                       cur_q, cur_d;
  logic [sgbn_pkg::OffsW-1:0] cs_q, cs_d, ce_q, ce_d;
  logic                       ov_q, ov_d;
  logic [sgbn_pkg::OffsW-1:0] os_q, os_d, oe_q, oe_d;
  logic                       on_q, on_d, oo_q, oo_d, ol_q, ol_d;
  logic                       out_free, touch;

  assign out_free = !ov_q || ready_i;
  // overlap or adjacency, one extra bit so end + 1 does not wrap
  assign touch = ({1'b0, ce_q} + 17'd1) >= {1'b0, head_i.start};

  always_comb begin
    cur_d = cur_q;
    cs_d  = cs_q;
    ce_d  = ce_q;
    ov_d  = ov_q && !ready_i;
    os_d  = os_q;
    oe_d  = oe_q;
    on_d  = on_q;
    oo_d  = oo_q;
    ol_d  = ol_q;
    stat_o = '0;
    if (emit_i) begin
      if (!cur_q) begin
        if (head_i.valid) begin
          // first block of the chunk
          cur_d = 1'b1;
          cs_d  = head_i.start;
          ce_d  = head_i.stop;
          stat_o.shift = 1'b1;
        end else if (out_free) begin
          // nothing survived
          ov_d = 1'b1;
          os_d = '0;
          oe_d = '0;
          on_d = 1'b1;
          oo_d = ovf_i;
          ol_d = 1'b1;
          stat_o.done = 1'b1;
        end
      end else if (head_i.valid && touch) begin
        if (head_i.stop > ce_q) begin
          ce_d = head_i.stop;
        end
        stat_o.shift = 1'b1;
      end else if (out_free) begin
        // close the current run
        ov_d = 1'b1;
        os_d = cs_q;
        oe_d = ce_q;
        on_d = 1'b0;
        oo_d = ovf_i;
        ol_d = !head_i.valid;
        if (head_i.valid) begin
          cs_d = head_i.start;
          ce_d = head_i.stop;
          stat_o.shift = 1'b1;
        end else begin
          cur_d = 1'b0;
          stat_o.done = 1'b1;
        end
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      cur_q <= cur_d;
      ov_q  <= ov_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cs_q <= cs_d;
    ce_q <= ce_d;
    os_q <= os_d;
    oe_q <= oe_d;
    on_q <= on_d;
    oo_q <= oo_d;
    ol_q <= ol_d;
  end

  assign valid_o = ov_q;
  assign start_o = os_q;
  assign stop_o  = oe_q;
  assign none_o  = on_q;
  assign ovf_o   = oo_q;
  assign last_o  = ol_q;

endmodule

### rtl/sack_gap_block_normalizer_core.sv
// Top level of the SACK gap block normalizer: cell chain, merge unit and control.
// Gap blocks of one SACK chunk arrive one per beat; the sorting cell chain
// places each accepted block in order in the same cycle. Blocks with end
// below start are dropped; beyond 32 held blocks they are dropped and every
// result of the chunk shows overflowed. The beat with tlast starts draining:
// the chain shifts one block per cycle into the merge unit, but a block that
// opens a new run waits for room in the output register, and no input beat
// is taken during the drain. A chunk with no surviving block gives a single
// result flagged none_left. A finished result waits in the output register
// while the next chunk is being loaded.
module sack_gap_block_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] block_start, [31:16] block_end
  input  logic        s_axis_tuser,  // [0] has_block
  input  logic        s_axis_tlast,  // final_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] merged_start, [31:16] merged_end
  output logic [1:0]  m_axis_tuser,  // [0] none_left, [1] overflowed
  output logic        m_axis_tlast   // last_result
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  localparam int unsigned N = sgbn_pkg::MaxBlocks;

  logic                  state_q, state_d;
  logic                  ovf_q, ovf_d;
  logic                  in_acc, blk_ok;
  sgbn_pkg::chain_ctrl_t ctrl;
  sgbn_pkg::merge_stat_t mstat;
  sgbn_pkg::blk_t        blk [N];
  logic                  take [N];
  logic                  full;
  logic                  chain_ok;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign blk_ok = s_axis_tuser && (s_axis_tdata[31:16] >= s_axis_tdata[15:0]);
  assign full   = blk[N-1].valid;

  // chain control
  always_comb begin
    ctrl.insert    = in_acc && blk_ok && !full;
    ctrl.shift     = mstat.shift;
    ctrl.blk_start = s_axis_tdata[15:0];
    ctrl.blk_stop  = s_axis_tdata[31:16];
  end

  // sequencer and overflow flag
  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (blk_ok && full) begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (mstat.done) begin
          state_d = StIdle;
          ovf_d   = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  // sorting cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    sgbn_pkg::blk_t prev_blk, next_blk;
    logic           prev_take;
    if (i == 0) begin : g_first
      assign prev_blk  = '0;
      assign prev_take = 1'b0;
    end else begin : g_mid
      assign prev_blk  = blk[i-1];
      assign prev_take = take[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_blk = '0;
    end else begin : g_inner
      assign next_blk = blk[i+1];
    end
    sgbn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_take_i (prev_take),
      .prev_blk_i  (prev_blk),
      .next_blk_i  (next_blk),
      .take_o      (take[i]),
      .blk_o       (blk[i])
    );
  end

  // merge unit and output register
  sgbn_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (state_q == StEmit),
    .head_i  (blk[0]),
    .ovf_i   (ovf_q),
    .ready_i (m_axis_tready),
    .stat_o  (mstat),
    .valid_o (m_axis_tvalid),
    .start_o (m_axis_tdata[15:0]),
    .stop_o  (m_axis_tdata[31:16]),
    .none_o  (m_axis_tuser[0]),
    .ovf_o   (m_axis_tuser[1]),
    .last_o  (m_axis_tlast)
  );

  // chain invariant: held blocks are packed at the front and sorted by start
  always_comb begin
    chain_ok = 1'b1;
    for (int unsigned i = 0; i + 1 < N; i++) begin
      if (blk[i+1].valid && (!blk[i].valid || (blk[i+1].start < blk[i].start))) begin
        chain_ok = 1'b0;
      end
    end
  end

  a_chain_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_ok)
    else $error("cell chain not packed and sorted");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mstat.done |=> !blk[0].valid)
    else $error("chain not empty after drain");

  a_no_shift_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !mstat.shift && !mstat.done)
    else $error("merge unit active while loading");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("empty-chunk result malformed");

endmodule

### tb/sv/tb_sack_gap_block_normalizer_core.sv
// Testbench for the SACK gap block normalizer: directed and random chunks, scoreboard checking.
`timescale 1ns / 100ps

module tb_sack_gap_block_normalizer_core;

  localparam int unsigned ItemTarget = 370;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 300;

  // One merged gap block as it should leave the block
  typedef struct packed {
    logic [sgbn_pkg::OffsW-1:0] start;
    logic [sgbn_pkg::OffsW-1:0] stop;
    logic                       none_left;
    logic                       ovf;
    logic                       is_last;
  } gap_res_t;

  // Scoreboard: collects blocks per chunk, sorts and merges on the closing beat
  class gap_scoreboard;
    logic [sgbn_pkg::OffsW-1:0] held_start[sgbn_pkg::MaxBlocks];
    logic [sgbn_pkg::OffsW-1:0] held_stop[sgbn_pkg::MaxBlocks];
    int unsigned      held_cnt;
    bit               lost_blk;
    gap_res_t         merged_q[$];
    int unsigned      errors;
    int unsigned      results_seen;
    int unsigned      chunk_cnt;
    int unsigned      ovf_chunks;
    int unsigned      empty_chunks;

    function void note_beat(logic [sgbn_pkg::OffsW-1:0] bs, logic [sgbn_pkg::OffsW-1:0] be,
                            bit has, bit fin);
      int unsigned                i;
      int unsigned                j;
      logic [sgbn_pkg::OffsW-1:0] ks;
      logic [sgbn_pkg::OffsW-1:0] ke;
      logic [sgbn_pkg::OffsW:0]   run_end;
      gap_res_t                   r;
      // load: reversed blocks vanish, a full store drops and flags
      if (has && be >= bs) begin
        if (held_cnt < sgbn_pkg::MaxBlocks) begin
          held_start[held_cnt] = bs;
          held_stop[held_cnt]  = be;
          held_cnt++;
        end else begin
          lost_blk = 1'b1;
        end
      end
      if (!fin) return;
      chunk_cnt++;
      if (lost_blk) ovf_chunks++;
      r = '0;
      r.ovf = lost_blk;
      if (held_cnt == 0) begin
        r.none_left = 1'b1;
        r.is_last   = 1'b1;
        merged_q.push_back(r);
        empty_chunks++;
      end else begin
        // stable insertion sort by start
        for (i = 1; i < held_cnt; i++) begin
          ks = held_start[i];
          ke = held_stop[i];
          j  = i;
          while (j > 0 && held_start[j-1] > ks) begin
            held_start[j] = held_start[j-1];
            held_stop[j]  = held_stop[j-1];
            j--;
          end
          held_start[j] = ks;
          held_stop[j]  = ke;
        end
        // merge overlapping or touching blocks, end + 1 taken without wrap
        r.start = held_start[0];
        r.stop  = held_stop[0];
        for (i = 1; i < held_cnt; i++) begin
          run_end = {1'b0, r.stop} + 1'b1;
          if (run_end >= {1'b0, held_start[i]}) begin
            if (held_stop[i] > r.stop) r.stop = held_stop[i];
          end else begin
            merged_q.push_back(r);
            r.start = held_start[i];
            r.stop  = held_stop[i];
          end
        end
        r.is_last = 1'b1;
        merged_q.push_back(r);
      end
      held_cnt = 0;
      lost_blk = 1'b0;
    endfunction

    function void check_beat(logic [31:0] data, logic [1:0] user, logic last);
      gap_res_t got;
      gap_res_t want;
      got.start     = data[15:0];
      got.stop      = data[31:16];
      got.none_left = user[0];
      got.ovf       = user[1];
      got.is_last   = last;
      results_seen++;
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected result start=%h end=%h none=%b ovf=%b last=%b", $time,
                 got.start, got.stop, got.none_left, got.ovf, got.is_last);
        errors++;
        return;
      end
      want = merged_q.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected start=%h end=%h none=%b ovf=%b last=%b", $time,
                 want.start, want.stop, want.none_left, want.ovf, want.is_last);
        $display("%0t:          actual   start=%h end=%h none=%b ovf=%b last=%b", $time,
                 got.start, got.stop, got.none_left, got.ovf, got.is_last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return merged_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  gap_scoreboard sb = new;
  int unsigned   items_sent;
  int unsigned   beats_sent;
  int unsigned   cycle_cnt;
  bit            quiet;
  bit            hold_req;

  sack_gap_block_normalizer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_sack_gap_block_normalizer_core: FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Receiver: random stalls, one long hold-off on request, none at the tail
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Offer one beat, with an optional idle burst ahead of it
  task automatic send_beat(logic [15:0] bs, logic [15:0] be, bit has, bit fin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {be, bs};
    s_axis_tuser  <= has;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(bs, be, has, fin);
    beats_sent++;
    items_sent++;
    if (items_sent + 50 >= ItemTarget) quiet = 1'b1;
  endtask

  // One chunk of n beats, blocks mostly clustered around a common base
  task automatic send_chunk(int unsigned n);
    logic [15:0] base;
    logic [15:0] bs;
    logic [15:0] be;
    logic [16:0] sum;
    bit          has;
    int unsigned k;
    case ($urandom_range(0, 7))
      0:       base = 16'h0000;
      1:       base = 16'hFF80;
      default: base = 16'($urandom_range(0, 65535));
    endcase
    for (k = 0; k < n; k++) begin
      has = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          has = 1'b0;
          bs  = 16'($urandom_range(0, 65535));
          be  = 16'($urandom_range(0, 65535));
        end
        1: begin
          bs = 16'($urandom_range(1, 65535));
          be = 16'($urandom_range(0, bs - 1));
        end
        2: begin
          bs = 16'($urandom_range(0, 65535));
          be = 16'($urandom_range(bs, 65535));
        end
        default: begin
          sum = 17'(base + $urandom_range(0, 80));
          bs  = sum[16] ? 16'hFFFF : sum[15:0];
          sum = 17'(bs + $urandom_range(0, 12));
          be  = sum[16] ? 16'hFFFF : sum[15:0];
        end
      endcase
      send_beat(bs, be, has, k == n - 1);
    end
  endtask

  // Main sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    items_sent    = 0;
    beats_sent    = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty chunk, closing beat carries no block
    send_beat(16'hA5A5, 16'h5A5A, 1'b0, 1'b1);
    // only a reversed block: nothing survives
    send_beat(16'd5, 16'd4, 1'b1, 1'b1);
    // single-point block at the top offset
    send_beat(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    // full-range block, closing beat without block
    send_beat(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_beat(16'h1234, 16'h0001, 1'b0, 1'b1);
    // out-of-order mix: overlap, touch, one-gap, ignored and reversed beats
    send_beat(16'd100, 16'd200, 1'b1, 1'b0);
    send_beat(16'd50, 16'd60, 1'b1, 1'b0);
    send_beat(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_beat(16'd61, 16'd70, 1'b1, 1'b0);
    send_beat(16'd150, 16'd300, 1'b1, 1'b0);
    send_beat(16'd20, 16'd10, 1'b1, 1'b0);
    send_beat(16'd0, 16'd0, 1'b1, 1'b0);
    send_beat(16'd1, 16'd1, 1'b1, 1'b0);
    send_beat(16'd3, 16'd3, 1'b1, 1'b0);
    send_beat(16'hFFFE, 16'hFFFF, 1'b1, 1'b0);
    send_beat(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_beat(16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    // equal starts
    send_beat(16'd500, 16'd600, 1'b1, 1'b0);
    send_beat(16'd500, 16'd550, 1'b1, 1'b0);
    send_beat(16'd500, 16'd600, 1'b1, 1'b1);

    // long output hold-off while big chunks keep coming
    hold_req = 1'b1;
    send_chunk(30);
    send_chunk(5);
    send_chunk(3);

    // random chunks, now and then past capacity
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0:       send_chunk($urandom_range(33, 36));
        1:       send_chunk($urandom_range(20, 32));
        default: send_chunk($urandom_range(1, 8));
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for a late stray result
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run covered %0d chunks (%0d empty, %0d past capacity), %0d beats in",
             sb.chunk_cnt, sb.empty_chunks, sb.ovf_chunks, beats_sent);
    $display("%0d merged results checked, %0d errors", sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sack_gap_block_normalizer_core: PASS");
    end else begin
      $display("tb_sack_gap_block_normalizer_core: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sgbn_pkg.sv
rtl/sgbn_cell.sv
rtl/sgbn_merge.sv
rtl/sack_gap_block_normalizer_core.sv
tb/sv/tb_sack_gap_block_normalizer_core.sv
